[src/asgd_pkg.sv]
// Shared types and constants for the averaged SGD weight update block.
// No dependencies; used by averaged_sgd_l1_weight_update.
package asgd_pkg;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 24;

    localparam int SCALE_W = 13;
    localparam int COUNT_W = 24;
    localparam int L1_W    = 16;

    localparam logic [CFG_AW-1:0] REG_BATCH_SCALE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BATCH_COUNT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_L1_STEP     = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 24'd1;
    localparam logic [L1_W-1:0]    L1_RESET    = 16'd2;

    typedef struct packed {
        logic signed [31:0] gradient;
        logic signed [31:0] weight;
        logic signed [47:0] avg_acc;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] new_weight;
        logic signed [47:0] new_avg_acc;
        logic signed [15:0] averaged_value;
        logic signed [15:0] rounded_weight;
    } t_out_word;

endpackage

[src/averaged_sgd_l1_weight_update.sv]
// Averaged SGD weight update with L1 pull toward zero, fully pipelined.
// Depends on asgd_pkg (word types, register indexes, reset values).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in      | sink      | i_valid / o_stall  | i_data  (asgd_pkg::t_in_word)
//  out     | source    | o_valid / i_stall  | o_data  (asgd_pkg::t_out_word)
//  config  | sink      | i_cfg_we           | i_cfg_addr, i_cfg_data
//
// One word enters per cycle while the output is not stalled; results leave in the order taken.
// The pipeline is built around two bit-serial restoring dividers laid out as stages:
// 32 stages for gradient / batch_scale and 17 for the averaging division.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// A stalled output word freezes the whole pipeline; o_stall then holds the input off.
module averaged_sgd_l1_weight_update #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  asgd_pkg::t_in_word             i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output asgd_pkg::t_out_word            o_data,
    input  logic                           i_cfg_we,
    input  logic [asgd_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [asgd_pkg::CFG_DW-1:0]    i_cfg_data
);

    localparam int SW  = asgd_pkg::SCALE_W;
    localparam int QA  = 32;                   // gradient divider steps
    localparam int QB  = 17;                   // averaging quotient bits
    localparam int DENW = asgd_pkg::COUNT_W + 1;
    localparam int DW  = DENW + FRAC_BITS;     // averaging divisor width
    localparam int CW  = (58 > DW + QB) ? 58 : DW + QB;

    // gradient divider stage
    typedef struct packed {
        logic [QA-1:0]      num;   // dividend bits, quotient shifts in low
        logic [SW-1:0]      rem;
        logic               neg;
        logic signed [31:0] w;
        logic signed [47:0] u;
    } t_da;

    // averaging divider stage
    typedef struct packed {
        logic [DW-1:0]      rem;
        logic [QB-1:0]      low;
        logic               neg;
        logic               ovf;
        logic signed [31:0] nw;
        logic signed [47:0] nu;
        logic signed [15:0] rw;
    } t_db;

    // configuration registers
    logic [SW-1:0]                 r_scale;
    logic [asgd_pkg::COUNT_W-1:0]  r_count;
    logic [asgd_pkg::L1_W-1:0]     r_l1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= asgd_pkg::SCALE_RESET;
            r_count <= asgd_pkg::COUNT_RESET;
            r_l1    <= asgd_pkg::L1_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                asgd_pkg::REG_BATCH_SCALE: r_scale <= i_cfg_data[SW-1:0];
                asgd_pkg::REG_BATCH_COUNT: r_count <= i_cfg_data[asgd_pkg::COUNT_W-1:0];
                asgd_pkg::REG_L1_STEP:     r_l1    <= i_cfg_data[asgd_pkg::L1_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DENW-1:0] w_den;
    logic [DW-1:0]   w_dvs;
    assign w_den = {1'b0, r_count} + DENW'(1);
    assign w_dvs = {w_den, FRAC_BITS'(0)};

    // round-half-away magnitude to signed 16 bit with saturation
    function automatic logic [15:0] sat16(logic neg, logic [33:0] q);
        logic [15:0] res;
        if (!neg) begin
            res = (q > 34'd32767) ? 16'h7FFF : q[15:0];
        end else begin
            res = (q > 34'd32768) ? 16'h8000 : (16'd0 - q[15:0]);
        end
        return res;
    endfunction

    function automatic t_da da_step(t_da s, logic [SW-1:0] d);
        logic [SW:0] t;
        t_da         o;
        o = s;
        t = {s.rem, s.num[QA-1]};
        if (t >= {1'b0, d}) begin
            t     = t - {1'b0, d};
            o.num = {s.num[QA-2:0], 1'b1};
        end else begin
            o.num = {s.num[QA-2:0], 1'b0};
        end
        o.rem = t[SW-1:0];
        return o;
    endfunction

    function automatic t_db db_step(t_db s, logic [DW-1:0] d);
        logic [DW:0] t;
        t_db         o;
        o = s;
        t = {s.rem, s.low[QB-1]};
        if (t >= {1'b0, d}) begin
            t     = t - {1'b0, d};
            o.low = {s.low[QB-2:0], 1'b1};
        end else begin
            o.low = {s.low[QB-2:0], 1'b0};
        end
        o.rem = t[DW-1:0];
        return o;
    endfunction

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // pipeline registers
    t_da                r_da [0:QA];
    logic [QA:0]        r_da_v;
    logic signed [34:0] r_f;
    logic signed [31:0] r_f_w;
    logic signed [47:0] r_f_u;
    logic               r_f_v;
    logic signed [31:0] r_m_nw;
    logic signed [59:0] r_m_prod;
    logic signed [47:0] r_m_u;
    logic               r_m_v;
    logic signed [31:0] r_n_nw;
    logic signed [47:0] r_n_nu;
    logic signed [57:0] r_n_nwd;
    logic               r_n_v;
    t_db                r_db [0:QB];
    logic [QB:0]        r_db_v;
    asgd_pkg::t_out_word r_out;
    logic                r_out_v;

    // next values
    t_da                n_da [0:QA];
    logic signed [34:0] n_f;
    logic signed [31:0] n_nw;
    logic signed [59:0] n_prod;
    logic signed [47:0] n_nu;
    logic signed [57:0] n_nwd;
    t_db                n_db [0:QB];
    asgd_pkg::t_out_word n_out;

    // load the gradient divider with |gradient|
    always_comb begin
        n_da[0].neg = i_data.gradient[31];
        n_da[0].num = i_data.gradient[31] ? (32'd0 - i_data.gradient) : i_data.gradient;
        n_da[0].rem = '0;
        n_da[0].w   = i_data.weight;
        n_da[0].u   = i_data.avg_acc;
        for (int k = 0; k < QA; k++) begin
            n_da[k+1] = da_step(r_da[k], r_scale);
        end
    end

    // round the gradient quotient and add the L1 term
    logic [SW:0]        w_rem2;
    logic [32:0]        w_qa;
    logic signed [34:0] w_gt;
    always_comb begin
        w_rem2 = {r_da[QA].rem, 1'b0};
        w_qa   = {1'b0, r_da[QA].num} + 33'(w_rem2 >= {1'b0, r_scale});
        if (r_scale == '0) begin
            w_gt = '0;
        end else if (r_da[QA].neg) begin
            w_gt = 35'sd0 - $signed({2'b00, w_qa});
        end else begin
            w_gt = $signed({2'b00, w_qa});
        end
        if (r_da[QA].w > 0) begin
            n_f = w_gt - $signed({19'd0, r_l1});
        end else if (r_da[QA].w < 0) begin
            n_f = w_gt + $signed({19'd0, r_l1});
        end else begin
            n_f = w_gt;
        end
    end

    // new weight and accumulator increment
    logic signed [35:0] w_nw_full;
    always_comb begin
        w_nw_full = 36'(r_f_w) + 36'(r_f);
        if (w_nw_full > 36'sh07FFFFFFF) begin
            n_nw = 32'sh7FFFFFFF;
        end else if (w_nw_full < -36'sh080000000) begin
            n_nw = -32'sh80000000;
        end else begin
            n_nw = w_nw_full[31:0];
        end
        n_prod = r_f * $signed({1'b0, r_count});
    end

    // new accumulator and scaled weight
    logic signed [60:0] w_nu_full;
    always_comb begin
        w_nu_full = 61'(r_m_u) + 61'(r_m_prod);
        if (w_nu_full > 61'sh07FFFFFFFFFFF) begin
            n_nu = 48'sh7FFFFFFFFFFF;
        end else if (w_nu_full < -61'sh0800000000000) begin
            n_nu = -48'sh800000000000;
        end else begin
            n_nu = w_nu_full[47:0];
        end
        n_nwd = r_m_nw * $signed({1'b0, w_den});
    end

    // averaging numerator, overflow check and rounded weight
    logic signed [58:0] w_num;
    logic [58:0]        w_mag;
    logic [CW-1:0]      w_a;
    logic [CW-1:0]      w_lim;
    logic [31:0]        w_wabs;
    logic [33:0]        w_wq;
    always_comb begin
        w_num  = 59'(r_n_nwd) - 59'(r_n_nu);
        w_mag  = w_num[58] ? (59'd0 - w_num) : w_num;
        w_a    = CW'(w_mag[57:0]);
        w_lim  = CW'({w_dvs, QB'(0)});
        w_wabs = r_n_nw[31] ? (32'd0 - r_n_nw) : r_n_nw;
        w_wq   = 34'(w_wabs >> FRAC_BITS) + 34'(w_wabs[FRAC_BITS-1]);
        n_db[0].neg = w_num[58];
        n_db[0].ovf = (w_a >= w_lim);
        n_db[0].rem = w_a[DW+QB-1:QB];
        n_db[0].low = w_a[QB-1:0];
        n_db[0].nw  = r_n_nw;
        n_db[0].nu  = r_n_nu;
        n_db[0].rw  = sat16(r_n_nw[31], w_wq);
        for (int k = 0; k < QB; k++) begin
            n_db[k+1] = db_step(r_db[k], w_dvs);
        end
    end

    // round the averaged quotient and build the output word
    logic [DW:0]    w_rb2;
    logic [QB:0]    w_qb;
    always_comb begin
        w_rb2 = {r_db[QB].rem, 1'b0};
        w_qb  = {1'b0, r_db[QB].low} + (QB+1)'(w_rb2 >= {1'b0, w_dvs});
        n_out.new_weight     = r_db[QB].nw;
        n_out.new_avg_acc    = r_db[QB].nu;
        n_out.rounded_weight = r_db[QB].rw;
        if (r_db[QB].ovf) begin
            n_out.averaged_value = r_db[QB].neg ? -16'sh8000 : 16'sh7FFF;
        end else begin
            n_out.averaged_value = sat16(r_db[QB].neg, 34'(w_qb));
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_da_v  <= '0;
            r_f_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_n_v   <= 1'b0;
            r_db_v  <= '0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_da_v  <= {r_da_v[QA-1:0], i_valid};
            r_f_v   <= r_da_v[QA];
            r_m_v   <= r_f_v;
            r_n_v   <= r_m_v;
            r_db_v  <= {r_db_v[QB-1:0], r_n_v};
            r_out_v <= r_db_v[QB];
        end
    end

    // payload, advance as one
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= QA; k++) begin
                r_da[k] <= n_da[k];
            end
            r_f      <= n_f;
            r_f_w    <= r_da[QA].w;
            r_f_u    <= r_da[QA].u;
            r_m_nw   <= n_nw;
            r_m_prod <= n_prod;
            r_m_u    <= r_f_u;
            r_n_nw   <= r_m_nw;
            r_n_nu   <= n_nu;
            r_n_nwd  <= n_nwd;
            for (int k = 0; k <= QB; k++) begin
                r_db[k] <= n_db[k];
            end
            r_out    <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // hold off input only while a finished word is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output word");

    // an accepted word enters the first divider stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_da_v[0])
        else $error("accepted word lost at pipeline entry");

    // a blocked output freezes the divider and output valid bits
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_da_v) && $stable(r_db_v) && $stable(r_out_v)))
        else $error("pipeline moved while stalled");

endmodule

[tb/averaged_sgd_l1_weight_update_tb.sv]
// Testbench for averaged_sgd_l1_weight_update: directed table plus random words,
// checked against a behavioral weight-update predictor. Depends on asgd_pkg.
`timescale 1ns / 1ps

module averaged_sgd_l1_weight_update_tb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    asgd_pkg::t_in_word            i_data;
    logic                          o_valid;
    logic                          i_stall;
    asgd_pkg::t_out_word           o_data;
    logic                          i_cfg_we;
    logic [asgd_pkg::CFG_AW-1:0]   i_cfg_addr;
    logic [asgd_pkg::CFG_DW-1:0]   i_cfg_data;

    averaged_sgd_l1_weight_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    localparam int FRAC = 16;
    localparam int LATENCY = 55;
    // Index past the register list; writes to it are dropped.
    localparam logic [asgd_pkg::CFG_AW-1:0] REG_NONE = 2'd3;

    // Predictor copy of the configuration registers.
    logic [asgd_pkg::SCALE_W-1:0] scale_q;
    logic [asgd_pkg::COUNT_W-1:0] count_q;
    logic [asgd_pkg::L1_W-1:0]    l1_q;

    asgd_pkg::t_out_word update_q[$];     // expected updates, oldest first
    int mismatches = 0;
    bit long_hold;              // receiver hold-off request
    bit hold_done;

    // Directed rows: known expectation only where it is obvious.
    typedef struct {
        asgd_pkg::t_in_word  in;
        bit                  known;
        asgd_pkg::t_out_word out;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Signed division rounded half away from zero; den > 0.
    function automatic longint round_div(longint num, longint den);
        longint a, q, r;
        a = (num < 0) ? -num : num;
        q = a / den;
        r = a % den;
        if (r >= den - r) q++;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic asgd_pkg::t_out_word weight_update(asgd_pkg::t_in_word w);
        longint g, wt, acc, step, nw, nacc, den, av, rw;
        asgd_pkg::t_out_word r;
        g    = longint'(w.gradient);
        wt   = longint'(w.weight);
        acc  = longint'(w.avg_acc);
        step = 0;
        if (scale_q != 0) step = round_div(g, longint'(scale_q));
        if (wt > 0) step -= longint'(l1_q);
        else if (wt < 0) step += longint'(l1_q);
        nw   = clamp(wt + step, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        nacc = clamp(acc + step * longint'(count_q), -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
        den  = longint'(count_q) + 1;
        av   = clamp(round_div(nw * den - nacc, den << FRAC), -32768, 32767);
        rw   = clamp(round_div(nw, 64'sd1 <<< FRAC), -32768, 32767);
        r.new_weight     = nw[31:0];
        r.new_avg_acc    = nacc[47:0];
        r.averaged_value = av[15:0];
        r.rounded_weight = rw[15:0];
        return r;
    endfunction

    // Write one register at a falling edge; mirror it in the predictor.
    task automatic write_reg(logic [asgd_pkg::CFG_AW-1:0] idx,
                             logic [asgd_pkg::CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            asgd_pkg::REG_BATCH_SCALE: scale_q = val[asgd_pkg::SCALE_W-1:0];
            asgd_pkg::REG_BATCH_COUNT: count_q = val[asgd_pkg::COUNT_W-1:0];
            asgd_pkg::REG_L1_STEP:     l1_q    = val[asgd_pkg::L1_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one word; hold it until taken. Leaves i_valid high.
    task automatic send_word(asgd_pkg::t_in_word w, bit known, asgd_pkg::t_out_word want);
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        update_q.insert(update_q.size(), known ? want : weight_update(w));
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Wait for every expectation to drain, then let the pipeline settle.
    task automatic drain;
        i_valid <= 1'b0;
        while (update_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic asgd_pkg::t_in_word rand_word(int mode);
        asgd_pkg::t_in_word w;
        w.gradient = $urandom;
        w.weight   = $urandom;
        w.avg_acc  = 48'({$urandom, $urandom});
        case (mode)
            0: begin    // modest values that keep averaging in range
                w.gradient = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                w.weight   = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
                w.avg_acc  = 48'(longint'(w.weight) * $urandom_range(0, 8)
                             + $signed($urandom_range(0, 65535)) - 32768);
            end
            1: w.weight = ($urandom_range(0, 3) == 0) ? 32'sd0 : w.weight;
            default: ;
        endcase
        return w;
    endfunction

    // Output checker: sample at the rising edge.
    always @(posedge i_clk) begin
        asgd_pkg::t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (update_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_data);
            end else begin
                want = update_q.pop_front();
                if (o_data.new_weight !== want.new_weight
                        || o_data.new_avg_acc !== want.new_avg_acc
                        || o_data.averaged_value !== want.averaged_value
                        || o_data.rounded_weight !== want.rounded_weight) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp w=%h acc=%h av=%h rw=%h got w=%h acc=%h av=%h rw=%h",
                                 want.new_weight, want.new_avg_acc, want.averaged_value,
                                 want.rounded_weight, o_data.new_weight, o_data.new_avg_acc,
                                 o_data.averaged_value, o_data.rounded_weight);
                end
            end
        end
    end

    // Receiver stall pattern; one long hold-off when requested.
    initial begin
        int mode;
        i_stall = 1'b0;
        hold_done = 1'b0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Run limit.
    initial begin
        #(20 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row r;
        asgd_pkg::t_out_word z;
        int burst;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        long_hold  = 1'b0;
        scale_q    = asgd_pkg::SCALE_RESET;
        count_q    = asgd_pkg::COUNT_RESET;
        l1_q       = asgd_pkg::L1_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // All-zero word after reset: zero update everywhere.
        z = '0;
        r.in = '0; r.known = 1'b1; r.out = z; rows.insert(rows.size(), r);
        // Positive weight of exactly 1.0: L1 pulls by two LSBs, rounds to 1.
        r.in = '{gradient: 0, weight: 32'sh0001_0000, avg_acc: 0}; r.known = 1'b1;
        r.out = '{new_weight: 32'sh0000_FFFE, new_avg_acc: -48'sd2,
                  averaged_value: 16'sd1, rounded_weight: 16'sd1};
        rows.insert(rows.size(), r);
        r.known = 1'b0;
        r.in = '{gradient: 32'sh7FFF_FFFF, weight: 32'sh7FFF_FFFF, avg_acc: 48'sh7FFF_FFFF_FFFF};
        rows.insert(rows.size(), r);
        r.in = '{gradient: 32'sh8000_0000, weight: 32'sh8000_0000, avg_acc: 48'sh8000_0000_0000};
        rows.insert(rows.size(), r);
        r.in = '{gradient: -32'sd1, weight: -32'sd1, avg_acc: -48'sd1};
        rows.insert(rows.size(), r);
        r.in = '{gradient: 32'sd2048, weight: 32'sd0, avg_acc: 48'sd0};
        rows.insert(rows.size(), r);
        r.in = '{gradient: -32'sd2048, weight: 32'sh0000_8000, avg_acc: 48'sd5};
        rows.insert(rows.size(), r);
        r.in = '{gradient: 32'sd6144, weight: -32'sh0000_8000, avg_acc: -48'sd7};
        rows.insert(rows.size(), r);
        foreach (rows[i]) send_word(rows[i].in, rows[i].known, rows[i].out);
        drain();

        // Zero scale, zero count, extreme L1 step.
        write_reg(asgd_pkg::REG_BATCH_SCALE, 24'd0);
        write_reg(asgd_pkg::REG_BATCH_COUNT, 24'd0);
        write_reg(asgd_pkg::REG_L1_STEP, 24'hFFFF);
        foreach (rows[i]) send_word(rows[i].in, 1'b0, z);
        send_word(rand_word(2), 1'b0, z);
        drain();

        // Largest scale and count, ignored index, out-of-range values truncated.
        write_reg(asgd_pkg::REG_BATCH_SCALE, 24'hFF_FFFF);
        write_reg(asgd_pkg::REG_BATCH_COUNT, 24'hFF_FFFF);
        write_reg(asgd_pkg::REG_L1_STEP, 24'hFF_0000);
        write_reg(REG_NONE, 24'h12_3456);
        foreach (rows[i]) send_word(rows[i].in, 1'b0, z);
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(asgd_pkg::REG_BATCH_SCALE, 24'd1);
                    write_reg(asgd_pkg::REG_BATCH_COUNT, 24'd1);
                    write_reg(asgd_pkg::REG_L1_STEP, 24'd0);
                end
                1: begin
                    write_reg(asgd_pkg::REG_BATCH_SCALE, 24'd4096);
                    write_reg(asgd_pkg::REG_BATCH_COUNT, 24'd16777215);
                    write_reg(asgd_pkg::REG_L1_STEP, 24'd65535);
                end
                default: begin
                    write_reg(asgd_pkg::REG_BATCH_SCALE, 24'($urandom_range(0, 8191)));
                    write_reg(asgd_pkg::REG_BATCH_COUNT, ($urandom_range(0, 1) == 0)
                              ? 24'($urandom_range(0, 40))
                              : 24'($urandom_range(0, 24'hFF_FFFF)));
                    write_reg(asgd_pkg::REG_L1_STEP, 24'($urandom_range(0, 65535)));
                end
            endcase
            for (int n = 0; n < 310; ) begin
                burst = $urandom_range(1, 40);
                // Hold the output long enough to back up the pipeline.
                if (ph == 2 && n == 0) long_hold = 1'b1;
                for (int k = 0; k < burst && n < 310; k++, n++)
                    send_word(rand_word($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2)),
                              1'b0, z);
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
            end
            drain();
        end

        if (mismatches == 0 && update_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
